// ===== rtl/core/wsfr_pkg.sv =====
// Shared types, codes and helpers for the frame receiver.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package wsfr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned TDATA_W = 24;
    localparam int unsigned TUSER_W = 8;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;

    typedef enum logic [2:0] {
        PH_HEAD0  = 3'd0,
        PH_HEAD1  = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_KEY    = 3'd4,
        PH_BODY   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_BINARY  = 3'd1,
        ACT_TEXT    = 3'd2,
        ACT_CLOSE   = 3'd3,
        ACT_PONG    = 3'd4,
        ACT_UNKNOWN = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_LEN64    = 2'd1,
        ERR_OVERSIZE = 2'd2
    } err_t;

    typedef struct packed {
        logic [LEN_W-1:0]  message_length;
        err_t              error_code;
        action_t           action;
        logic              message_end;
        logic              has_data;
        logic [BYTE_W-1:0] data_byte;
    } result_t;

    function automatic action_t action_of(input logic [3:0] op);
        action_t act;
        case (op)
            OP_TEXT:   act = ACT_TEXT;
            OP_BINARY: act = ACT_BINARY;
            OP_CLOSE:  act = ACT_CLOSE;
            OP_PING:   act = ACT_PONG;
            default:   act = ACT_UNKNOWN;
        endcase
        return act;
    endfunction

endpackage

// ===== rtl/core/wsfr_parser.sv =====
// Header parser, unmasking and message accounting for the frame receiver.
// Depends on wsfr_pkg; feeds at most one result per accepted byte to wsfr_out_stage.
`timescale 1ns / 1ps

module wsfr_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [wsfr_pkg::LEN_W-1:0]    cfg_wdata,
    input  logic                          in_accept,
    input  logic [wsfr_pkg::BYTE_W-1:0]   in_byte,
    output logic                          res_valid,
    output wsfr_pkg::result_t             res
);
    import wsfr_pkg::*;

    phase_t                  phase_reg, phase_next;
    logic                    final_reg, final_next;
    logic [3:0]              opcode_reg, opcode_next;
    logic                    mask_reg, mask_next;
    logic [LEN_W-1:0]        left_reg, left_next;
    logic [3:0][BYTE_W-1:0]  key_reg, key_next;
    logic [1:0]              kidx_reg, kidx_next;
    logic [LEN_W-1:0]        total_reg, total_next;
    logic                    halted_reg, halted_next;
    logic [LEN_W-1:0]        limit_reg;

    logic                    len_known;
    logic [LEN_W-1:0]        len_val;
    logic [LEN_W:0]          len_sum;
    logic                    finish;
    logic                    err_len64;
    logic [BYTE_W-1:0]       key_byte;

    always_comb begin
        phase_next  = phase_reg;
        final_next  = final_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        left_next   = left_reg;
        key_next    = key_reg;
        kidx_next   = kidx_reg;
        total_next  = total_reg;
        halted_next = halted_reg;
        res_valid   = 1'b0;
        res         = '0;
        len_known   = 1'b0;
        len_val     = left_reg;
        len_sum     = '0;
        finish      = 1'b0;
        err_len64   = 1'b0;
        key_byte    = mask_reg ? key_reg[kidx_reg] : '0;

        if (in_accept && !halted_reg) begin
            case (phase_reg)
                PH_HEAD0: begin
                    final_next = in_byte[7];
                    // A continuation frame keeps the opcode of the frame that opened the message.
                    if (in_byte[3:0] != OP_CONT) begin
                        opcode_next = in_byte[3:0];
                    end
                    mask_next  = 1'b0;
                    left_next  = '0;
                    kidx_next  = '0;
                    phase_next = PH_HEAD1;
                end
                PH_HEAD1: begin
                    mask_next = in_byte[7];
                    if (in_byte[6:0] == LEN_EXT64) begin
                        err_len64 = 1'b1;
                    end else if (in_byte[6:0] == LEN_EXT16) begin
                        phase_next = PH_LEN_HI;
                    end else begin
                        len_val   = {{(LEN_W-7){1'b0}}, in_byte[6:0]};
                        left_next = len_val;
                        len_known = 1'b1;
                    end
                end
                PH_LEN_HI: begin
                    left_next  = {in_byte, {(LEN_W-BYTE_W){1'b0}}};
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    len_val   = {left_reg[LEN_W-1:BYTE_W], in_byte};
                    left_next = len_val;
                    len_known = 1'b1;
                end
                PH_KEY: begin
                    key_next[kidx_reg] = in_byte;
                    kidx_next          = kidx_reg + 2'd1;
                    if (kidx_reg == 2'd3) begin
                        if (left_reg == '0) begin
                            finish = 1'b1;
                        end else begin
                            phase_next = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    res_valid     = 1'b1;
                    res.data_byte = in_byte ^ key_byte;
                    res.has_data  = 1'b1;
                    if (mask_reg) begin
                        kidx_next = kidx_reg + 2'd1;
                    end
                    left_next = left_reg - {{(LEN_W-1){1'b0}}, 1'b1};
                    if (left_next == '0) begin
                        finish = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_HEAD0;
                end
            endcase

            if (len_known) begin
                len_sum = {1'b0, total_reg} + {1'b0, len_val};
                if (len_sum > {1'b0, limit_reg}) begin
                    res_valid      = 1'b1;
                    res            = '0;
                    res.error_code = ERR_OVERSIZE;
                    halted_next    = 1'b1;
                end else begin
                    total_next = len_sum[LEN_W-1:0];
                    if (mask_next) begin
                        kidx_next  = '0;
                        key_next   = '0;
                        phase_next = PH_KEY;
                    end else if (len_val == '0) begin
                        finish = 1'b1;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end
            end

            if (err_len64) begin
                res_valid      = 1'b1;
                res            = '0;
                res.error_code = ERR_LEN64;
                halted_next    = 1'b1;
            end

            if (finish) begin
                phase_next = PH_HEAD0;
                if (final_reg) begin
                    res_valid          = 1'b1;
                    res.message_end    = 1'b1;
                    res.action         = action_of(opcode_reg);
                    res.message_length = total_next;
                    total_next         = '0;
                    if (res.action == ACT_CLOSE) begin
                        halted_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEAD0;
            final_reg  <= 1'b0;
            opcode_reg <= OP_CONT;
            mask_reg   <= 1'b0;
            left_reg   <= '0;
            key_reg    <= '0;
            kidx_reg   <= '0;
            total_reg  <= '0;
            halted_reg <= 1'b0;
            limit_reg  <= LEN_W'(1024);
        end else begin
            phase_reg  <= phase_next;
            final_reg  <= final_next;
            opcode_reg <= opcode_next;
            mask_reg   <= mask_next;
            left_reg   <= left_next;
            key_reg    <= key_next;
            kidx_reg   <= kidx_next;
            total_reg  <= total_next;
            halted_reg <= halted_next;
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
        end
    end

`ifndef SYNTHESIS
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("parser left the halted state without reset");

    a_body_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY) |-> (left_reg != '0))
        else $error("payload phase entered with no bytes left");

    a_error_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.error_code != ERR_NONE)
            |-> (!res.has_data && !res.message_end) ##1 halted_reg)
        else $error("error result carried data or did not halt the parser");
`endif

endmodule

// ===== rtl/core/wsfr_out_stage.sv =====
// Result register with a skid entry for the frame receiver.
// Depends on wsfr_pkg; decouples the parser from stalls on the result side.
`timescale 1ns / 1ps

module wsfr_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  wsfr_pkg::result_t push_data,
    output logic              in_ready,
    output logic              out_valid,
    output wsfr_pkg::result_t out_data,
    input  logic              out_ready
);
    import wsfr_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg, skid_data_next;

    // The input side only stalls once the skid entry holds a beat.
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a beat while the output register is empty");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && out_ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid beat did not move to the output register");

    a_stall_catches: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready && push) |=> skid_valid_reg)
        else $error("beat pushed during a stall was not caught by the skid entry");
`endif

endmodule

// ===== rtl/core/websocket_frame_receiver.sv =====
// Top level of the frame receiver: stream ports, beat packing and the two stages.
// Depends on wsfr_pkg, wsfr_parser and wsfr_out_stage.
`timescale 1ns / 1ps

// Usage:
// The slave channel takes the received connection bytes, one byte per beat in
// s_tdata. The master channel gives at most one result beat per input beat:
// an unmasked payload byte, the end of a final frame with its action and the
// message length, or an error. Header bytes that finish nothing give no beat.
// cfg_we/cfg_wdata set the payload limit; write it only while the block is idle.
// A result is registered in the output register, or in the skid entry while the
// master channel stalls. The block takes one byte per cycle while s_tready is high;
// the parser forms each result combinationally from the accepted byte and its registers.
// Reset clears the parser to expect the first header byte, clears the halt,
// and sets the payload limit to 1024.
// When the receiver stalls, one further result is held in a skid entry; only
// then does s_tready fall, and it rises again in the cycle after the receiver
// takes a beat.
// After a length error, an over-limit message or a final close frame the block
// ignores every byte until reset.
module websocket_frame_receiver (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [wsfr_pkg::LEN_W-1:0]       cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // rx_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [wsfr_pkg::TDATA_W-1:0]     m_tdata,   // data_byte, message_length
    output logic [wsfr_pkg::TUSER_W-1:0]     m_tuser,   // has_data, action, error_code, zero pad
    output logic                             m_tlast    // message_end
);
    import wsfr_pkg::*;

    logic    in_accept;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign in_accept = s_tvalid && s_tready;

    wsfr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    wsfr_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {out_res.message_length, out_res.data_byte};
    assign m_tuser = {2'b00, out_res.error_code, out_res.action, out_res.has_data};
    assign m_tlast = out_res.message_end;

endmodule
